FILE: rtl/mscma_pkg.sv
`timescale 1ns / 1ps

package mscma_pkg;

  localparam int DATA_W  = 16;
  localparam int CH_W    = 2;
  localparam int CENTI_W = 18;
  localparam int ERR_W   = 4;
  localparam int COEF_W  = 32;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE = 2'd2;

  localparam logic signed [COEF_W-1:0] OFFSET_RESET = 32'sd0;
  localparam logic signed [COEF_W-1:0] LINEAR_RESET = 32'sd65536;
  localparam logic signed [COEF_W-1:0] SQUARE_RESET = 32'sd0;

  // shared multiplier: signed 33 x 33 covers a signed coefficient times an unsigned 32-bit square
  localparam int MUL_W  = COEF_W + 1;
  localparam int PROD_W = 2 * MUL_W;

  // calibration accumulator, Q.16 before the final floor
  localparam int ACC_W = 51;

  // 273.15 K in hundredths; the sensor LSB is 0.02 K
  localparam int KELVIN_CENTI = 27315;

  localparam int DEF_WINDOW_SIZE = 16;
  localparam int DEF_CHANNELS    = 4;

endpackage

FILE: rtl/mscma_in_if.sv
`timescale 1ns / 1ps

interface mscma_in_if;
  logic                           valid;
  logic                           ready;
  logic [mscma_pkg::CH_W-1:0]     channel;
  logic                           read_failed;
  logic [mscma_pkg::DATA_W-1:0]   raw_reading;

  modport source (output valid, channel, read_failed, raw_reading, input ready);
  modport sink   (input valid, channel, read_failed, raw_reading, output ready);
endinterface

FILE: rtl/mscma_out_if.sv
`timescale 1ns / 1ps

interface mscma_out_if;
  logic                                valid;
  logic                                ready;
  logic [mscma_pkg::CH_W-1:0]          out_channel;
  logic [mscma_pkg::DATA_W-1:0]        window_mean;
  logic signed [mscma_pkg::CENTI_W-1:0] celsius_centi;
  logic [mscma_pkg::ERR_W-1:0]         error_bits;
  logic [mscma_pkg::DATA_W-1:0]        all_channel_mean;
  logic                                none_valid;

  modport source (output valid, out_channel, window_mean, celsius_centi, error_bits,
                  all_channel_mean, none_valid, input ready);
  modport sink   (input valid, out_channel, window_mean, celsius_centi, error_bits,
                  all_channel_mean, none_valid, output ready);
endinterface

FILE: rtl/mscma_mul.sv
`timescale 1ns / 1ps

module mscma_mul (
  input  logic                                clk,
  input  logic signed [mscma_pkg::MUL_W-1:0]  a,
  input  logic signed [mscma_pkg::MUL_W-1:0]  b,
  output logic signed [mscma_pkg::PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: rtl/mscma_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module mscma_div #(
  parameter int DVD_W = 20,
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] work;
  logic [DVS_W:0]   rem;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_next;
  logic             fits;
  logic [CNT_W-1:0] cnt;

  assign rem_sh   = {rem[DVS_W-1:0], work[DVD_W-1]};
  assign fits     = rem_sh >= {1'b0, divisor};
  assign rem_next = fits ? rem_sh - {1'b0, divisor} : rem_sh;
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend shifts out at the top while quotient bits fill in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
    end else if (busy) begin
      work <= {work[DVD_W-2:0], fits};
      rem  <= rem_next;
    end
  end

endmodule

FILE: rtl/multi_sensor_calibrated_moving_average.sv
`timescale 1ns / 1ps

// Per-channel quadratic calibration followed by a boxcar moving average over WINDOW_SIZE
// samples. One request is taken at a time. DW = 16 + clog2(CHANNELS+1) is the width of the
// bit-serial divider that forms the cross-channel mean; the window mean comes from a multiply
// by the reciprocal of WINDOW_SIZE. A failed read or an unused channel skips the calibration
// and the window update, and the division is skipped when no channel is valid. The next
// request can be taken in the cycle after the result is loaded. The square, quadratic,
// linear and reciprocal products share one registered 33x33 multiplier. A result waiting on
// the output does not stop the next request being accepted, but the following result holds
// the sequence in its last step until the waiting one is taken. Coefficients must only be
// written while idle.
module multi_sensor_calibrated_moving_average #(
  parameter int WINDOW_SIZE = mscma_pkg::DEF_WINDOW_SIZE,
  parameter int CHANNELS    = mscma_pkg::DEF_CHANNELS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mscma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mscma_pkg::COEF_W-1:0]         cfg_data,
  mscma_in_if.sink                             sample,
  mscma_out_if.source                          result
);

  localparam int DATA_W  = mscma_pkg::DATA_W;
  localparam int MUL_W   = mscma_pkg::MUL_W;
  localparam int PROD_W  = mscma_pkg::PROD_W;
  localparam int ACC_W   = mscma_pkg::ACC_W;
  localparam int COEF_W  = mscma_pkg::COEF_W;
  localparam int CENTI_W = mscma_pkg::CENTI_W;
  localparam int ERR_W   = mscma_pkg::ERR_W;

  localparam int PW      = $clog2(WINDOW_SIZE);
  localparam int CHW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW      = CHW + PW;
  localparam int DEPTH   = 1 << AW;
  localparam int RSW     = DATA_W + PW;
  localparam int RSW1    = RSW + 1;
  localparam int CNTW    = $clog2(CHANNELS + 1);
  localparam int ASW     = DATA_W + CNTW;
  localparam int DW      = ASW;
  localparam int CHX     = CHW + mscma_pkg::CH_W;
  localparam int FEW     = CHANNELS + ERR_W;

  // window mean = (rsum * WIN_RECIP) >> WSH, exact for every sum below 2^RSW
  localparam int     WSH       = RSW + PW;
  localparam longint WIN_RECIP = ((longint'(1) << WSH) + longint'(WINDOW_SIZE) - 1)
                                 / longint'(WINDOW_SIZE);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SQ     = 4'd1;
  localparam logic [3:0] S_QUAD   = 4'd2;
  localparam logic [3:0] S_LIN    = 4'd3;
  localparam logic [3:0] S_ACC    = 4'd4;
  localparam logic [3:0] S_UPD    = 4'd5;
  localparam logic [3:0] S_MDIV   = 4'd6;
  localparam logic [3:0] S_AGG    = 4'd7;
  localparam logic [3:0] S_ASTART = 4'd8;
  localparam logic [3:0] S_ADIV   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;

  logic signed [COEF_W-1:0] coef_offset;
  logic signed [COEF_W-1:0] coef_linear;
  logic signed [COEF_W-1:0] coef_square;

  // request held for the length of the sequence
  logic [mscma_pkg::CH_W-1:0] ch_r;
  logic [CHW-1:0]             ch_idx_r;
  logic                       ch_ok_r;
  logic                       failed_r;
  logic [DATA_W-1:0]          raw_r;

  logic [CHX-1:0] ch_ext;
  logic [CHW-1:0] ch_idx;
  logic           ch_ok;
  logic           accept;

  // per-channel state
  logic [PW-1:0]     wpos     [CHANNELS];
  logic [RSW-1:0]    rsum     [CHANNELS];
  logic [DATA_W-1:0] chan_mean[CHANNELS];
  logic [CHANNELS-1:0] filled;
  logic [CHANNELS-1:0] failed_flags;

  logic [DATA_W-1:0] ring [DEPTH];
  logic [AW-1:0]     ring_addr;
  logic [DATA_W-1:0] ring_q;
  logic              ring_we;
  logic [DATA_W-1:0] old_sample;

  // calibration datapath
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  quad_acc;
  logic signed [ACC_W-1:0]  acc;
  logic [DATA_W-1:0]        y_sat;
  logic [DATA_W-1:0]        y_r;

  logic [RSW1-1:0] rsum_calc;
  logic [RSW-1:0]  rsum_new;

  // divider
  logic            div_start;
  logic            div_busy;
  logic [DW-1:0]   div_dividend;
  logic [CNTW-1:0] div_divisor;
  logic [DW-1:0]   div_q;

  // cross-channel sweep
  logic [CHW-1:0]    agg_idx;
  logic [ASW-1:0]    agg_sum;
  logic [CNTW-1:0]   agg_cnt;
  logic [DATA_W-1:0] mean_r;

  // output register
  logic                      res_valid;
  logic                      out_free;
  logic [mscma_pkg::CH_W-1:0] res_channel;
  logic [DATA_W-1:0]         res_mean;
  logic signed [CENTI_W-1:0] res_centi;
  logic [ERR_W-1:0]          res_err;
  logic [DATA_W-1:0]         res_all;
  logic                      res_none;
  logic [FEW-1:0]            flags_ext;

  assign ch_ext = CHX'(sample.channel);
  assign ch_idx = ch_ext[CHW-1:0];
  assign ch_ok  = 32'(sample.channel) < CHANNELS;

  assign sample.ready = (state == S_IDLE);
  assign accept       = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_offset <= mscma_pkg::OFFSET_RESET;
      coef_linear <= mscma_pkg::LINEAR_RESET;
      coef_square <= mscma_pkg::SQUARE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mscma_pkg::CFG_OFFSET: coef_offset <= cfg_data;
        mscma_pkg::CFG_LINEAR: coef_linear <= cfg_data;
        mscma_pkg::CFG_SQUARE: coef_square <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (state)
      S_SQ: begin
        mul_a = MUL_W'(raw_r);
        mul_b = MUL_W'(raw_r);
      end
      S_QUAD: begin
        mul_a = MUL_W'(coef_square);
        mul_b = MUL_W'(prod[31:0]);
      end
      S_UPD: begin
        mul_a = MUL_W'(rsum_new);
        mul_b = MUL_W'(WIN_RECIP);
      end
      default: begin
        mul_a = MUL_W'(coef_linear);
        mul_b = MUL_W'(raw_r);
      end
    endcase
  end

  mscma_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign acc = quad_acc + ACC_W'(signed'(prod[ACC_W-2:0]));

  always_comb begin
    if (acc[ACC_W-1]) begin
      y_sat = '0;
    end else if (acc[ACC_W-2:32] != '0) begin
      y_sat = '1;
    end else begin
      y_sat = acc[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LIN) begin
      // prod holds coef_square * x^2 here; floor by 2^16 is the arithmetic shift
      quad_acc <= ACC_W'(coef_offset) + ACC_W'(signed'(prod[PROD_W-1:16]));
    end
    if (state == S_ACC) begin
      y_r <= y_sat;
    end
  end

  // an entry not yet written since reset reads as zero
  assign old_sample = filled[ch_idx_r] ? ring_q : '0;
  assign rsum_calc  = RSW1'(rsum[ch_idx_r]) - RSW1'(old_sample) + RSW1'(y_r);
  assign rsum_new   = rsum_calc[RSW-1:0];
  assign ring_we    = (state == S_UPD);

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_addr] <= y_r;
    end
    ring_q <= ring[ring_addr];
  end

  assign div_start    = (state == S_ASTART) && (agg_cnt != '0);
  assign div_dividend = DW'(agg_sum);
  assign div_divisor  = agg_cnt;

  mscma_div #(
    .DVD_W (DW),
    .DVS_W (CNTW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_free = !res_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      failed_flags <= '0;
      filled       <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        wpos[c]      <= '0;
        rsum[c]      <= '0;
        chan_mean[c] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!ch_ok) begin
              state <= S_AGG;
            end else if (sample.read_failed) begin
              failed_flags[ch_idx] <= 1'b1;
              state                <= S_AGG;
            end else begin
              failed_flags[ch_idx] <= 1'b0;
              state                <= S_SQ;
            end
          end
        end
        S_SQ:   state <= S_QUAD;
        S_QUAD: state <= S_LIN;
        S_LIN:  state <= S_ACC;
        S_ACC:  state <= S_UPD;
        S_UPD: begin
          rsum[ch_idx_r] <= rsum_new;
          if (wpos[ch_idx_r] == PW'(WINDOW_SIZE - 1)) begin
            wpos[ch_idx_r]   <= '0;
            filled[ch_idx_r] <= 1'b1;
          end else begin
            wpos[ch_idx_r] <= wpos[ch_idx_r] + 1'b1;
          end
          state <= S_MDIV;
        end
        S_MDIV: begin
          // prod holds rsum * WIN_RECIP
          chan_mean[ch_idx_r] <= prod[WSH +: DATA_W];
          state               <= S_AGG;
        end
        S_AGG: begin
          if (agg_idx == CHW'(CHANNELS - 1)) begin
            state <= S_ASTART;
          end
        end
        S_ASTART: state <= S_ADIV;
        S_ADIV: begin
          if (!div_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r      <= sample.channel;
      ch_idx_r  <= ch_idx;
      ch_ok_r   <= ch_ok;
      failed_r  <= sample.read_failed;
      raw_r     <= sample.raw_reading;
      ring_addr <= {ch_idx, wpos[ch_idx]};
      agg_idx   <= '0;
      agg_sum   <= '0;
      agg_cnt   <= '0;
      mean_r    <= '0;
    end else if (state == S_AGG) begin
      agg_idx <= agg_idx + 1'b1;
      if (!failed_flags[agg_idx]) begin
        agg_sum <= agg_sum + ASW'(chan_mean[agg_idx]);
        agg_cnt <= agg_cnt + 1'b1;
      end
      // the request's own mean is picked up as the sweep passes it
      if (ch_ok_r && (agg_idx == ch_idx_r)) begin
        mean_r <= chan_mean[agg_idx];
      end
    end
  end

  assign flags_ext = FEW'(failed_flags);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      res_channel <= ch_r;
      res_mean    <= mean_r;
      res_centi   <= {1'b0, mean_r, 1'b0} - CENTI_W'(mscma_pkg::KELVIN_CENTI);
      res_err     <= flags_ext[ERR_W-1:0];
      res_all     <= (agg_cnt == '0) ? '0 : div_q[DATA_W-1:0];
      res_none    <= (agg_cnt == '0);
    end
  end

  assign result.valid            = res_valid;
  assign result.out_channel      = res_channel;
  assign result.window_mean      = res_mean;
  assign result.celsius_centi    = res_centi;
  assign result.error_bits       = res_err;
  assign result.all_channel_mean = res_all;
  assign result.none_valid       = res_none;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_ring_write_good: assert property (@(posedge clk) disable iff (rst)
    ring_we |-> (ch_ok_r && !failed_r))
    else $error("sample ring written for a failed or unused channel");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the final step");

  a_none_valid_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.none_valid) |-> (result.all_channel_mean == '0))
    else $error("non-zero cross-channel mean with no valid channel");

  a_accept_not_busy: assert property (@(posedge clk) disable iff (rst)
    accept |-> (!div_busy && !ring_we))
    else $error("request accepted while a sequence is in flight");
`endif

endmodule
